/* design/csp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

	localparam int CORDIC_STEPS_DEF      = 20;
	localparam int MAX_MIDDLE_POINTS_DEF = 7;

	// arctangent of 2^-i as a binary angle, 2^32 units per turn
	localparam int ATAN_LEN = 30;
	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
		32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
		32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
		32'd20,        32'd10,        32'd5,         32'd3,        32'd1
	};

	// inverse cordic gain, Q0.28
	localparam logic [27:0] INV_GAIN = 28'd163008219;

	localparam int GUARD   = 8;   // extra fraction bits in the rotation datapath
	localparam int DIFF_W  = 33;  // difference of two 32 bit coordinates
	localparam int VEC_W   = 36;  // vectoring datapath
	localparam int ROT_W   = 42;  // rotation datapath
	localparam int ROT_ZW  = 34;  // rotation angle accumulator
	localparam int MAG_W   = 34;  // magnitude out of the vectoring unit
	localparam int SH_W    = 6;   // normalizing shift, 0 to 32

	typedef enum logic [1:0] {
		REG_CENTER_X  = 2'd0,
		REG_CENTER_Y  = 2'd1,
		REG_RADIUS    = 2'd2,
		REG_TOLERANCE = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

/* design/csp_vec_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module csp_vec_cell #(
	parameter int STEP = 0,
	parameter int SW   = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [csp_pkg::VEC_W-1:0]  in_x,
	input  logic signed [csp_pkg::VEC_W-1:0]  in_y,
	input  logic [31:0]                       in_z,
	input  logic [SW-1:0]                     in_side,
	output logic                              out_valid,
	output logic signed [csp_pkg::VEC_W-1:0]  out_x,
	output logic signed [csp_pkg::VEC_W-1:0]  out_y,
	output logic [31:0]                       out_z,
	output logic [SW-1:0]                     out_side
);
	import csp_pkg::*;

	logic                    valid_q;
	logic signed [VEC_W-1:0] x_q, y_q;
	logic [31:0]             z_q;
	logic [SW-1:0]           side_q;
	logic                    y_pos;

	assign y_pos = !in_y[VEC_W-1] && (in_y != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// drive y toward zero
	always_ff @(posedge clk) begin
		if (y_pos) begin
			x_q <= in_x + (in_y >>> STEP);
			y_q <= in_y - (in_x >>> STEP);
			z_q <= in_z + ATAN_TAB[STEP];
		end else begin
			x_q <= in_x - (in_y >>> STEP);
			y_q <= in_y + (in_x >>> STEP);
			z_q <= in_z - ATAN_TAB[STEP];
		end
		side_q <= in_side;
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_side  = side_q;

endmodule

`default_nettype wire

/* design/csp_rot_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module csp_rot_cell #(
	parameter int STEP = 0,
	parameter int SW   = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [csp_pkg::ROT_W-1:0]   in_x,
	input  logic signed [csp_pkg::ROT_W-1:0]   in_y,
	input  logic signed [csp_pkg::ROT_ZW-1:0]  in_z,
	input  logic [SW-1:0]                      in_side,
	output logic                               out_valid,
	output logic signed [csp_pkg::ROT_W-1:0]   out_x,
	output logic signed [csp_pkg::ROT_W-1:0]   out_y,
	output logic signed [csp_pkg::ROT_ZW-1:0]  out_z,
	output logic [SW-1:0]                      out_side
);
	import csp_pkg::*;

	logic                     valid_q;
	logic signed [ROT_W-1:0]  x_q, y_q;
	logic signed [ROT_ZW-1:0] z_q;
	logic [SW-1:0]            side_q;
	logic signed [ROT_ZW-1:0] atan_ext;

	assign atan_ext = $signed({{(ROT_ZW-32){1'b0}}, ATAN_TAB[STEP]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// drive the residual angle toward zero
	always_ff @(posedge clk) begin
		if (!in_z[ROT_ZW-1]) begin
			x_q <= in_x - (in_y >>> STEP);
			y_q <= in_y + (in_x >>> STEP);
			z_q <= in_z - atan_ext;
		end else begin
			x_q <= in_x + (in_y >>> STEP);
			y_q <= in_y - (in_x >>> STEP);
			z_q <= in_z + atan_ext;
		end
		side_q <= in_side;
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_side  = side_q;

endmodule

`default_nettype wire

/* design/csp_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module csp_div_cell #(
	parameter int CW   = 4,
	parameter int NUMW = 37,
	parameter int SW   = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [CW-1:0]   in_rem,
	input  logic [NUMW-1:0] in_num,
	input  logic [31:0]     in_quo,
	input  logic [CW-1:0]   in_div,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [CW-1:0]   out_rem,
	output logic [NUMW-1:0] out_num,
	output logic [31:0]     out_quo,
	output logic [CW-1:0]   out_div,
	output logic [SW-1:0]   out_side
);

	logic            valid_q;
	logic [CW-1:0]   rem_q, div_q;
	logic [NUMW-1:0] num_q;
	logic [31:0]     quo_q;
	logic [SW-1:0]   side_q;
	logic [CW:0]     trial, trial_sub;
	logic            fits;

	assign trial     = {in_rem, in_num[NUMW-1]};
	assign fits      = trial >= {1'b0, in_div};
	assign trial_sub = trial - {1'b0, in_div};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	// one restoring quotient bit, quotient kept modulo 2^32
	always_ff @(posedge clk) begin
		rem_q  <= fits ? trial_sub[CW-1:0] : trial[CW-1:0];
		num_q  <= {in_num[NUMW-2:0], 1'b0};
		quo_q  <= {in_quo[30:0], fits};
		div_q  <= in_div;
		side_q <= in_side;
	end

	assign out_valid = valid_q;
	assign out_rem   = rem_q;
	assign out_num   = num_q;
	assign out_quo   = quo_q;
	assign out_div   = div_q;
	assign out_side  = side_q;

endmodule

`default_nettype wire

/* design/csp_vectoring.sv */
`timescale 1ns / 1ps
`default_nettype none

module csp_vectoring #(
	parameter int STEPS = csp_pkg::CORDIC_STEPS_DEF,
	parameter int SW    = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [csp_pkg::DIFF_W-1:0]  in_x,
	input  logic signed [csp_pkg::DIFF_W-1:0]  in_y,
	input  logic [SW-1:0]                      in_side,
	output logic                               out_valid,
	output logic [csp_pkg::MAG_W-1:0]          out_mag,
	output logic [31:0]                        out_ang,
	output logic [SW-1:0]                      out_side
);
	import csp_pkg::*;

	localparam int CSW    = SW + SH_W + 1;
	localparam int HI_W   = VEC_W - 18;
	localparam int PLO_W  = 17 + 28;
	localparam int PHI_W  = HI_W + 28;
	localparam int MSUM_W = PHI_W + 17 + 1;
	localparam int RND_W  = MAG_W + 1;

	// stage 1: fold into the right half plane
	logic                   v_s1, zero_s1, neg_s1;
	logic signed [DIFF_W:0] xa_s1, ya_s1;
	logic [SW-1:0]          side_s1;
	logic signed [DIFF_W:0] ex, ey;

	assign ex = {in_x[DIFF_W-1], in_x};
	assign ey = {in_y[DIFF_W-1], in_y};

	always_ff @(posedge clk) begin
		zero_s1 <= (in_x == '0) && (in_y == '0);
		neg_s1  <= in_x[DIFF_W-1];
		xa_s1   <= in_x[DIFF_W-1] ? -ex : ex;
		ya_s1   <= in_x[DIFF_W-1] ? -ey : ey;
		side_s1 <= in_side;
	end

	// stage 2: leading zero count of the larger component
	logic                   v_s2, zero_s2, neg_s2;
	logic signed [DIFF_W:0] xa_s2, ya_s2;
	logic [SH_W-1:0]        sh_s2;
	logic [SW-1:0]          side_s2;
	logic signed [DIFF_W:0] ay, mbig;
	logic [SH_W-1:0]        sh_c;

	assign ay   = ya_s1[DIFF_W] ? -ya_s1 : ya_s1;
	assign mbig = (xa_s1 > ay) ? xa_s1 : ay;

	always_comb begin
		sh_c = SH_W'(32);
		for (int b = 0; b < 32; b++) begin
			if (mbig[b]) begin
				sh_c = SH_W'(31 - b);
			end
		end
	end

	always_ff @(posedge clk) begin
		zero_s2 <= zero_s1;
		neg_s2  <= neg_s1;
		xa_s2   <= xa_s1;
		ya_s2   <= ya_s1;
		sh_s2   <= sh_c;
		side_s2 <= side_s1;
	end

	// stage 3: normalize
	logic                   v_s3;
	logic signed [VEC_W-1:0] x_s3, y_s3;
	logic [31:0]            z_s3;
	logic [CSW-1:0]         cs_s3;

	always_ff @(posedge clk) begin
		x_s3  <= $signed({{(VEC_W-DIFF_W-1){xa_s2[DIFF_W]}}, xa_s2}) <<< sh_s2;
		y_s3  <= $signed({{(VEC_W-DIFF_W-1){ya_s2[DIFF_W]}}, ya_s2}) <<< sh_s2;
		z_s3  <= neg_s2 ? 32'h8000_0000 : 32'h0000_0000;
		cs_s3 <= {sh_s2, zero_s2, side_s2};
	end

	// cell chain
	logic                    cv [STEPS+1];
	logic signed [VEC_W-1:0] cx [STEPS+1];
	logic signed [VEC_W-1:0] cy [STEPS+1];
	logic [31:0]             cz [STEPS+1];
	logic [CSW-1:0]          cside [STEPS+1];

	assign cv[0]    = v_s3;
	assign cx[0]    = x_s3;
	assign cy[0]    = y_s3;
	assign cz[0]    = z_s3;
	assign cside[0] = cs_s3;

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		csp_vec_cell #(.STEP(i), .SW(CSW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.in_valid(cv[i]), .in_x(cx[i]), .in_y(cy[i]), .in_z(cz[i]), .in_side(cside[i]),
			.out_valid(cv[i+1]), .out_x(cx[i+1]), .out_y(cy[i+1]), .out_z(cz[i+1]),
			.out_side(cside[i+1])
		);
	end

	// stage 4: gain correction as two partial products
	logic               v_s4;
	logic [PLO_W-1:0]   plo_s4;
	logic [PHI_W-1:0]   phi_s4;
	logic [31:0]        z_s4;
	logic [CSW-1:0]     cs_s4;
	logic [VEC_W-1:0]   xf;

	assign xf = cx[STEPS];

	always_ff @(posedge clk) begin
		plo_s4 <= PLO_W'(xf[16:0]) * PLO_W'(INV_GAIN);
		phi_s4 <= PHI_W'(xf[VEC_W-2:17]) * PHI_W'(INV_GAIN);
		z_s4   <= cz[STEPS];
		cs_s4  <= cside[STEPS];
	end

	// stage 5: sum and round off the gain fraction
	logic               v_s5;
	logic [RND_W-1:0]   m_s5;
	logic [31:0]        z_s5;
	logic [CSW-1:0]     cs_s5;
	logic [MSUM_W-1:0]  msum;

	assign msum = (MSUM_W'(phi_s4) << 17) + MSUM_W'(plo_s4) + (MSUM_W'(1) << 27);

	always_ff @(posedge clk) begin
		m_s5  <= RND_W'(msum >> 28);
		z_s5  <= z_s4;
		cs_s5 <= cs_s4;
	end

	// stage 6: undo normalization with rounding
	logic               v_s6;
	logic [MAG_W-1:0]   mag_s6;
	logic [31:0]        ang_s6;
	logic [SW-1:0]      side_s6;
	logic [SH_W-1:0]    sh5;
	logic               zero5;
	logic [RND_W-1:0]   half, rsum;

	assign sh5   = cs_s5[CSW-1 -: SH_W];
	assign zero5 = cs_s5[SW];
	assign half  = (sh5 == '0) ? '0 : (RND_W'(1) << (sh5 - 1'b1));
	assign rsum  = (m_s5 + half) >> sh5;

	always_ff @(posedge clk) begin
		mag_s6  <= zero5 ? '0 : rsum[MAG_W-1:0];
		ang_s6  <= zero5 ? '0 : z_s5;
		side_s6 <= cs_s5[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= cv[STEPS];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_mag   = mag_s6;
	assign out_ang   = ang_s6;
	assign out_side  = side_s6;

endmodule

`default_nettype wire

/* design/circle_snap_point_finder.sv */
`timescale 1ns / 1ps
`default_nettype none

// a query runs from start to done through the three cordic cell chains and the snap divider
//   chain of NUM_W cells, NUM_W = clog2(MAX+2) + 33
// throughput: one query per cycle, busy never rises; done is a one cycle strobe
// reset: arst_n clears the pipeline valid bits and loads the register reset values
//   (center 0, radius 1.0, tolerance 1 lsb); no clearing pass
module circle_snap_point_finder #(
	parameter int CORDIC_STEPS      = csp_pkg::CORDIC_STEPS_DEF,
	parameter int MAX_MIDDLE_POINTS = csp_pkg::MAX_MIDDLE_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// query channel
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic signed [31:0] query_x,
	input  logic signed [31:0] query_y,
	input  logic [2:0]         middle_points,
	// result channel
	output logic               done,
	output logic               point_valid,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic [31:0]        distance,
	// register write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import csp_pkg::*;

	localparam int NBW   = $clog2(MAX_MIDDLE_POINTS + 1);   // saturated n
	localparam int CW    = $clog2(MAX_MIDDLE_POINTS + 2);   // snap points per quadrant
	localparam int KW    = CW + 3;                          // snap index
	localparam int NUM_W = KW + 30;                         // divider numerator
	localparam int SA_W  = 1 + 32 + 32 + NBW;
	localparam int SD_W  = 1 + 1 + 32 + 32 + 32;
	localparam int SR_W  = 1 + 1 + 32 + 32;
	localparam int SB_W  = 1 + 32 + 32;
	localparam int OX_W  = ROT_W - GUARD;
	localparam int RP_W  = 31 + 28;

	//------------------------------------------------------------------
	// registers; the block does not enforce it, but writes must only arrive while the pipeline is empty
	//------------------------------------------------------------------
	logic signed [31:0] center_x_q, center_y_q;
	logic [30:0]        radius_q;
	logic [15:0]        tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= 31'd65536;
			tol_q      <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:  center_x_q <= cfg_data;
				REG_CENTER_Y:  center_y_q <= cfg_data;
				REG_RADIUS:    radius_q   <= cfg_data[30:0];
				REG_TOLERANCE: tol_q      <= cfg_data[15:0];
				default:       ;
			endcase
		end
	end

	// fully pipelined, every cycle takes a beat
	assign busy = 1'b0;

	//------------------------------------------------------------------
	// stage 1: offset from the centre, clamp n
	//------------------------------------------------------------------
	logic                      v_s1;
	logic                      mode_s1;
	logic signed [31:0]        qx_s1, qy_s1;
	logic [NBW-1:0]            n_s1;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		qx_s1   <= query_x;
		qy_s1   <= query_y;
		n_s1    <= (32'(middle_points) > 32'(MAX_MIDDLE_POINTS)) ?
		           NBW'(MAX_MIDDLE_POINTS) : NBW'(middle_points);
		dx_s1   <= {query_x[31], query_x} - {center_x_q[31], center_x_q};
		dy_s1   <= {query_y[31], query_y} - {center_y_q[31], center_y_q};
	end

	//------------------------------------------------------------------
	// first vectoring pass: centre distance and angle of the query
	//------------------------------------------------------------------
	logic             va_valid;
	logic [MAG_W-1:0] va_mag;
	logic [31:0]      va_ang;
	logic [SA_W-1:0]  va_side;

	csp_vectoring #(.STEPS(CORDIC_STEPS), .SW(SA_W)) u_vec_a (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s1), .in_x(dx_s1), .in_y(dy_s1),
		.in_side({mode_s1, qx_s1, qy_s1, n_s1}),
		.out_valid(va_valid), .out_mag(va_mag), .out_ang(va_ang), .out_side(va_side)
	);

	logic               a_mode;
	logic signed [31:0] a_qx, a_qy;
	logic [NBW-1:0]     a_n;
	logic [CW-1:0]      a_c;
	logic [CW+32:0]     kprod;

	assign a_n    = va_side[NBW-1:0];
	assign a_qy   = va_side[NBW+31:NBW];
	assign a_qx   = va_side[NBW+63:NBW+32];
	assign a_mode = va_side[NBW+64];
	assign a_c    = CW'(a_n) + CW'(1);
	assign kprod  = (CW+33)'(a_c) * (CW+33)'(va_ang) + (CW+33)'(32'h2000_0000);

	//------------------------------------------------------------------
	// stage 2: special cases, nearest snap index
	//------------------------------------------------------------------
	logic               v_s2, inv_s2, mode_s2, nz_s2;
	logic [31:0]        theta_s2;
	logic signed [31:0] qx_s2, qy_s2;
	logic [CW-1:0]      c_s2;
	logic [KW-1:0]      k_s2;
	logic [1:0]         quad_s2;

	always_ff @(posedge clk) begin
		// query within tolerance of the centre, or a snap on a degenerate circle
		inv_s2   <= (va_mag == '0) || (va_mag < MAG_W'(tol_q)) ||
		            (a_mode && (radius_q <= 31'(tol_q)));
		mode_s2  <= a_mode;
		nz_s2    <= (a_n != '0);
		theta_s2 <= va_ang;
		qx_s2    <= a_qx;
		qy_s2    <= a_qy;
		c_s2     <= a_c;
		k_s2     <= kprod[CW+32:30];
		quad_s2  <= va_ang[31:30];
	end

	//------------------------------------------------------------------
	// stage 3: step off the quadrant points, form the divider numerator
	//------------------------------------------------------------------
	logic               v_s3, inv_s3, mode_s3, nz_s3;
	logic [31:0]        theta_s3;
	logic signed [31:0] qx_s3, qy_s3;
	logic [CW-1:0]      c_s3;
	logic [KW-1:0]      k_s3;
	logic [1:0]         quad_s3;
	logic [NUM_W-1:0]   num_s3;
	logic [KW-1:0]      qs, k_adj;

	always_comb begin
		qs    = k_s2 - KW'(quad_s2) * KW'(c_s2);
		k_adj = k_s2;
		if (nz_s2) begin
			if (qs == '0) begin
				k_adj = k_s2 + 1'b1;
			end else if (qs == KW'(c_s2)) begin
				k_adj = k_s2 - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		inv_s3   <= inv_s2;
		mode_s3  <= mode_s2;
		nz_s3    <= nz_s2;
		theta_s3 <= theta_s2;
		qx_s3    <= qx_s2;
		qy_s3    <= qy_s2;
		c_s3     <= c_s2;
		k_s3     <= k_adj;
		quad_s3  <= quad_s2;
		num_s3   <= {k_adj, 30'd0} + NUM_W'(c_s2 >> 1);
	end

	//------------------------------------------------------------------
	// divider chain: target angle = round(k * quarter turn / c)
	//------------------------------------------------------------------
	logic             dv [NUM_W+1];
	logic [CW-1:0]    drem [NUM_W+1];
	logic [NUM_W-1:0] dnum [NUM_W+1];
	logic [31:0]      dquo [NUM_W+1];
	logic [CW-1:0]    ddiv [NUM_W+1];
	logic [SD_W-1:0]  dside [NUM_W+1];

	assign dv[0]    = v_s3;
	assign drem[0]  = '0;
	assign dnum[0]  = num_s3;
	assign dquo[0]  = '0;
	assign ddiv[0]  = c_s3;
	assign dside[0] = {inv_s3, mode_s3, theta_s3, qx_s3, qy_s3};

	for (genvar i = 0; i < NUM_W; i++) begin : g_div
		csp_div_cell #(.CW(CW), .NUMW(NUM_W), .SW(SD_W)) u_div (
			.clk(clk), .arst_n(arst_n),
			.in_valid(dv[i]), .in_rem(drem[i]), .in_num(dnum[i]), .in_quo(dquo[i]),
			.in_div(ddiv[i]), .in_side(dside[i]),
			.out_valid(dv[i+1]), .out_rem(drem[i+1]), .out_num(dnum[i+1]),
			.out_quo(dquo[i+1]), .out_div(ddiv[i+1]), .out_side(dside[i+1])
		);
	end

	//------------------------------------------------------------------
	// stage 4: pick the target, fold it into the right half, load radius
	//------------------------------------------------------------------
	logic [SD_W-1:0]            dend;
	logic [31:0]                tgt, tsum, afold;
	logic                       tflip;
	logic [RP_W-1:0]            rprod;

	assign dend  = dside[NUM_W];
	assign tgt   = dend[96] ? dquo[NUM_W] : dend[95:64];
	assign tsum  = tgt + 32'h4000_0000;
	assign tflip = tsum[31];
	assign afold = tflip ? (tgt + 32'h8000_0000) : tgt;
	assign rprod = RP_W'(radius_q) * RP_W'(INV_GAIN);

	logic                     v_s4, inv_s4, flip_s4;
	logic signed [ROT_W-1:0]  x0_s4;
	logic signed [ROT_ZW-1:0] z0_s4;
	logic signed [31:0]       qx_s4, qy_s4;

	always_ff @(posedge clk) begin
		inv_s4  <= dend[97];
		flip_s4 <= tflip;
		x0_s4   <= $signed(ROT_W'(rprod >> (28 - GUARD)));
		z0_s4   <= $signed({{(ROT_ZW-32){afold[31]}}, afold});
		qx_s4   <= dend[63:32];
		qy_s4   <= dend[31:0];
	end

	//------------------------------------------------------------------
	// rotation chain: radius vector at the target angle
	//------------------------------------------------------------------
	logic                     rv [CORDIC_STEPS+1];
	logic signed [ROT_W-1:0]  rx [CORDIC_STEPS+1];
	logic signed [ROT_W-1:0]  ry [CORDIC_STEPS+1];
	logic signed [ROT_ZW-1:0] rz [CORDIC_STEPS+1];
	logic [SR_W-1:0]          rside [CORDIC_STEPS+1];

	assign rv[0]    = v_s4;
	assign rx[0]    = x0_s4;
	assign ry[0]    = '0;
	assign rz[0]    = z0_s4;
	assign rside[0] = {inv_s4, flip_s4, qx_s4, qy_s4};

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		csp_rot_cell #(.STEP(i), .SW(SR_W)) u_rot (
			.clk(clk), .arst_n(arst_n),
			.in_valid(rv[i]), .in_x(rx[i]), .in_y(ry[i]), .in_z(rz[i]), .in_side(rside[i]),
			.out_valid(rv[i+1]), .out_x(rx[i+1]), .out_y(ry[i+1]), .out_z(rz[i+1]),
			.out_side(rside[i+1])
		);
	end

	//------------------------------------------------------------------
	// stage 5: unfold and drop the guard bits with rounding
	//------------------------------------------------------------------
	logic [SR_W-1:0]         rend;
	logic signed [ROT_W-1:0] xr, yr;
	logic [ROT_W-1:0]        xrnd, yrnd;

	assign rend = rside[CORDIC_STEPS];
	assign xr   = rend[64] ? -rx[CORDIC_STEPS] : rx[CORDIC_STEPS];
	assign yr   = rend[64] ? -ry[CORDIC_STEPS] : ry[CORDIC_STEPS];
	assign xrnd = xr + (ROT_W'(1) << (GUARD - 1));
	assign yrnd = yr + (ROT_W'(1) << (GUARD - 1));

	logic                    v_s5, inv_s5;
	logic signed [OX_W-1:0]  ox_s5, oy_s5;
	logic signed [31:0]      qx_s5, qy_s5;

	always_ff @(posedge clk) begin
		inv_s5 <= rend[65];
		ox_s5  <= $signed(xrnd[ROT_W-1:GUARD]);
		oy_s5  <= $signed(yrnd[ROT_W-1:GUARD]);
		qx_s5  <= rend[63:32];
		qy_s5  <= rend[31:0];
	end

	//------------------------------------------------------------------
	// stage 6: add the centre and clamp to 32 bits
	//------------------------------------------------------------------
	logic [OX_W:0] sx, sy;

	assign sx = {{(OX_W-31){center_x_q[31]}}, center_x_q} + {ox_s5[OX_W-1], ox_s5};
	assign sy = {{(OX_W-31){center_y_q[31]}}, center_y_q} + {oy_s5[OX_W-1], oy_s5};

	logic               v_s6, inv_s6;
	logic signed [31:0] px_s6, py_s6, qx_s6, qy_s6;

	always_ff @(posedge clk) begin
		inv_s6 <= inv_s5;
		if (sx[OX_W:31] == '0 || sx[OX_W:31] == '1) begin
			px_s6 <= sx[31:0];
		end else begin
			px_s6 <= sx[OX_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		if (sy[OX_W:31] == '0 || sy[OX_W:31] == '1) begin
			py_s6 <= sy[31:0];
		end else begin
			py_s6 <= sy[OX_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		qx_s6 <= qx_s5;
		qy_s6 <= qy_s5;
	end

	//------------------------------------------------------------------
	// stage 7: offset from query to result point
	//------------------------------------------------------------------
	logic                     v_s7, inv_s7;
	logic signed [DIFF_W-1:0] dx_s7, dy_s7;
	logic signed [31:0]       px_s7, py_s7;

	always_ff @(posedge clk) begin
		inv_s7 <= inv_s6;
		dx_s7  <= {qx_s6[31], qx_s6} - {px_s6[31], px_s6};
		dy_s7  <= {qy_s6[31], qy_s6} - {py_s6[31], py_s6};
		px_s7  <= px_s6;
		py_s7  <= py_s6;
	end

	//------------------------------------------------------------------
	// second vectoring pass: distance to the result point
	//------------------------------------------------------------------
	logic             vb_valid;
	logic [MAG_W-1:0] vb_mag;
	logic [31:0]      vb_ang;
	logic [SB_W-1:0]  vb_side;

	csp_vectoring #(.STEPS(CORDIC_STEPS), .SW(SB_W)) u_vec_b (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s7), .in_x(dx_s7), .in_y(dy_s7),
		.in_side({inv_s7, px_s7, py_s7}),
		.out_valid(vb_valid), .out_mag(vb_mag), .out_ang(vb_ang), .out_side(vb_side)
	);

	// the angle of the second pass is not needed; fold it into nothing
	logic vb_ang_unused;
	assign vb_ang_unused = ^vb_ang;

	//------------------------------------------------------------------
	// result register
	//------------------------------------------------------------------
	logic               done_q, pv_q;
	logic signed [31:0] px_q, py_q;
	logic [31:0]        dist_q;
	logic               b_inv;

	assign b_inv = vb_side[64];

	always_ff @(posedge clk) begin
		pv_q   <= !b_inv;
		px_q   <= b_inv ? '0 : vb_side[63:32];
		py_q   <= b_inv ? '0 : vb_side[31:0];
		if (b_inv || (vb_mag[MAG_W-1:32] != '0) || vb_ang_unused && 1'b0) begin
			dist_q <= '1;
		end else begin
			dist_q <= vb_mag[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= va_valid;
			v_s3   <= v_s2;
			v_s4   <= dv[NUM_W];
			v_s5   <= rv[CORDIC_STEPS];
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			done_q <= vb_valid;
		end
	end

	assign done        = done_q;
	assign point_valid = pv_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign distance    = dist_q;

	//------------------------------------------------------------------
	// checks
	//------------------------------------------------------------------
	// an invalid beat carries the zero point and a saturated distance
	a_invalid_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done && !point_valid |-> (point_x == 32'sd0) && (point_y == 32'sd0) &&
		(distance == 32'hFFFF_FFFF))
		else $error("invalid result not in canonical form");

	// with middle points, a snap never lands on a quadrant point
	a_skip_quadrant: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && mode_s3 && nz_s3 |->
		(k_s3 != KW'(quad_s3) * KW'(c_s3)) && (k_s3 != KW'(quad_s3) * KW'(c_s3) + KW'(c_s3)))
		else $error("snap index on a quadrant point");

	// the divider leaves a remainder below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv[NUM_W] |-> (drem[NUM_W] < ddiv[NUM_W]))
		else $error("divider remainder out of range");

	// an in-range magnitude is passed straight through
	a_dist_pass: assert property (@(posedge clk) disable iff (!arst_n)
		vb_valid && !b_inv && (vb_mag[MAG_W-1:32] == '0) |=> point_valid &&
		(distance == $past(vb_mag[31:0])))
		else $error("distance not taken from second pass");

endmodule

`default_nettype wire

/* sim/circle_snap_point_finder_tb.sv */
`timescale 1ns / 1ps

module circle_snap_point_finder_tb;
	import csp_pkg::*;

	// one result beat as the block should present it
	typedef struct packed {
		bit        ok;
		bit [31:0] px;
		bit [31:0] py;
		bit [31:0] gap;
	} snap_answer_t;

	// directed stimulus row; fixed rows carry a hand-typed answer
	typedef struct packed {
		bit        mode;
		bit [31:0] qx;
		bit [31:0] qy;
		bit [2:0]  n;
		bit        fixed;
		bit        ok;
		bit [31:0] px;
		bit [31:0] py;
		bit [31:0] gap;
	} query_row_t;

	localparam int  NUM_ROWS    = 20;
	localparam int  DRAIN_WAIT  = 140;   // a bit above the pipeline latency
	localparam int  STALL_LIMIT = 4000;  // cycles with no beat at all
	localparam int  DUE_DEPTH   = 256;   // well above the beats in flight
	localparam bit [31:0] MAXP  = 32'h7fffffff;
	localparam bit [31:0] MINP  = 32'h80000000;
	localparam bit [31:0] ONES  = 32'hffffffff;
	localparam bit [31:0] TWO   = 32'h00020000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               mode = 1'b0;
	logic signed [31:0] query_x = '0;
	logic signed [31:0] query_y = '0;
	logic [2:0]         middle_points = '0;
	logic               done;
	logic               point_valid;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic [31:0]        distance;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// hand-typed answer riding along with the query beat
	logic               row_fixed = 1'b0;
	snap_answer_t       row_answer = '0;

	circle_snap_point_finder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.query_x       (query_x),
		.query_y       (query_y),
		.middle_points (middle_points),
		.done          (done),
		.point_valid   (point_valid),
		.point_x       (point_x),
		.point_y       (point_y),
		.distance      (distance),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// shadow copy of the circle registers
	longint      shadow_cx = 0;
	longint      shadow_cy = 0;
	bit [31:0]   shadow_radius = 32'd65536;
	bit [31:0]   shadow_tol = 32'd1;

	// expected answers in order, a ring with write and read counts
	snap_answer_t due_fifo [DUE_DEPTH];
	int           due_wr = 0;
	int           due_rd = 0;
	int           errors = 0;
	int           quiet_cycles = 0;
	bit           idle_bursts = 1'b1;
	query_row_t   rows [NUM_ROWS];

	// floor shift, as the datapath does on signed values
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// magnitude and binary angle of a difference vector
	function automatic void cordic_vector(longint x, longint y,
		output longint unsigned mag, output bit [31:0] ang);
		bit [31:0]       z;
		longint unsigned m, ay;
		int              sh;
		longint          xn;
		z = 0;
		sh = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			ang = 0;
			return;
		end
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h80000000;
		end
		ay = (y < 0) ? longint'(-y) : longint'(y);
		m = (longint'(x) > longint'(ay)) ? x : ay;
		while (m < 64'h80000000) begin
			m = m << 1;
			sh++;
		end
		x = x <<< sh;
		y = y <<< sh;
		for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++) begin
			if (y > 0) begin
				xn = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z = z + ATAN_TAB[i];
			end else begin
				xn = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z = z - ATAN_TAB[i];
			end
			x = xn;
		end
		m = (longint'(x) * longint'(INV_GAIN) + (64'd1 << 27)) >> 28;
		if (sh > 0)
			m = (m + (64'd1 << (sh - 1))) >> sh;
		mag = m;
		ang = z;
	endfunction

	// point at radius r and binary angle a, rounded to whole lsbs
	function automatic void cordic_rotate(bit [31:0] r, bit [31:0] a,
		output longint ox, output longint oy);
		longint x, y, z, xn;
		bit     flip;
		x = longint'((longint'(r) * longint'(INV_GAIN)) >> (28 - GUARD));
		y = 0;
		flip = 1'b0;
		if (((a + 32'h40000000) & 32'h80000000) != 0) begin
			flip = 1'b1;
			a = a + 32'h80000000;
		end
		z = longint'(signed'(a));
		for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++) begin
			if (z >= 0) begin
				xn = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z = z - longint'(ATAN_TAB[i]);
			end else begin
				xn = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z = z + longint'(ATAN_TAB[i]);
			end
			x = xn;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		ox = floor_shr(x + (1 << (GUARD - 1)), GUARD);
		oy = floor_shr(y + (1 << (GUARD - 1)), GUARD);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// nearest circle or snap point for one query under the shadow registers
	function automatic snap_answer_t snap_point(bit m, bit [31:0] qx_b, bit [31:0] qy_b,
		bit [2:0] n);
		snap_answer_t    ans;
		longint          qx, qy, ox, oy, px, py;
		longint unsigned d, gap_len, c, k, qs;
		bit [31:0]       theta, target;
		qx = longint'(signed'(qx_b));
		qy = longint'(signed'(qy_b));
		cordic_vector(qx - shadow_cx, qy - shadow_cy, d, theta);
		// query within tolerance of the centre, or a degenerate circle for snapping
		if (d == 0 || d < shadow_tol || (m && shadow_radius <= shadow_tol)) begin
			ans.ok = 1'b0;
			ans.px = '0;
			ans.py = '0;
			ans.gap = ONES;
			return ans;
		end
		target = theta;
		if (m) begin
			c = longint'(n) + 1;
			k = (c * theta + 64'h20000000) >> 30;
			// quadrant points are skipped when middle points exist
			if (n > 0) begin
				qs = k - longint'(theta >> 30) * c;
				if (qs == 0)
					k++;
				else if (qs == c)
					k--;
			end
			target = 32'(((k << 30) + c / 2) / c);
		end
		cordic_rotate(shadow_radius, target, ox, oy);
		px = clamp32(shadow_cx + ox);
		py = clamp32(shadow_cy + oy);
		cordic_vector(qx - px, qy - py, gap_len, theta);
		if (gap_len > 64'hffffffff)
			gap_len = 64'hffffffff;
		ans.ok = 1'b1;
		ans.px = px[31:0];
		ans.py = py[31:0];
		ans.gap = gap_len[31:0];
		return ans;
	endfunction

	// watch every beat on all three channels
	always @(posedge clk) begin
		snap_answer_t want;
		if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:  shadow_cx = longint'(signed'(cfg_data));
				REG_CENTER_Y:  shadow_cy = longint'(signed'(cfg_data));
				REG_RADIUS:    shadow_radius = {1'b0, cfg_data[30:0]};
				REG_TOLERANCE: shadow_tol = {16'd0, cfg_data[15:0]};
			endcase
		end
		if (start && !busy) begin
			due_fifo[due_wr % DUE_DEPTH] = row_fixed ? row_answer
				: snap_point(mode, query_x, query_y, middle_points);
			due_wr++;
		end
		if (done) begin
			if (due_wr == due_rd) begin
				$display("%0t: result beat with nothing expected", $time);
				errors++;
			end else begin
				want = due_fifo[due_rd % DUE_DEPTH];
				due_rd++;
				if (point_valid !== want.ok) begin
					$display("%0t: point_valid expected %0d got %0d", $time, want.ok, point_valid);
					errors++;
				end
				if (point_x !== want.px) begin
					$display("%0t: point_x expected %h got %h", $time, want.px, point_x);
					errors++;
				end
				if (point_y !== want.py) begin
					$display("%0t: point_y expected %h got %h", $time, want.py, point_y);
					errors++;
				end
				if (distance !== want.gap) begin
					$display("%0t: distance expected %h got %h", $time, want.gap, distance);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles that move no beat
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// valid stays high across a run of writes; the caller drops it afterwards
	task automatic write_reg(cfg_reg_t idx, bit [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// one query beat; a random burst of idle cycles may come first
	task automatic send_query(bit m, bit [31:0] qx, bit [31:0] qy, bit [2:0] n,
		bit fixed, snap_answer_t ans);
		if (idle_bursts && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		query_x <= qx;
		query_y <= qy;
		middle_points <= n;
		row_fixed <= fixed;
		row_answer <= ans;
		do
			@(posedge clk);
		while (busy);
	endtask

	// let every answer drain before the circle changes
	task automatic drain();
		start <= 1'b0;
		while (due_wr != due_rd)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		bit [31:0] ox, oy, cx, cy;
		int        pick;
		rows = '{
			// query at the centre is invalid in both modes
			'{1'b0, 32'd0, 32'd0, 3'd0, 1'b1, 1'b0, 32'd0, 32'd0, ONES},
			'{1'b1, 32'd0, 32'd0, 3'd3, 1'b1, 1'b0, 32'd0, 32'd0, ONES},
			// coordinate extremes
			'{1'b0, MAXP, MAXP, 3'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b0, MINP, MINP, 3'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, MAXP, MINP, 3'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, MINP, MAXP, 3'd7, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b0, MINP, 32'd0, 3'd5, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			// every snap count on the positive x axis
			'{1'b1, TWO, 32'd0, 3'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, TWO, 32'd0, 3'd1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, TWO, 32'd0, 3'd2, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, TWO, 32'd0, 3'd3, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, TWO, 32'd0, 3'd4, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, TWO, 32'd0, 3'd5, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, TWO, 32'd0, 3'd6, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, TWO, 32'd0, 3'd7, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			// quadrant points replaced by neighbours on the other axes
			'{1'b1, 32'd0, TWO, 3'd1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, -TWO, 32'd0, 3'd2, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			'{1'b1, 32'd0, -TWO, 3'd4, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			// just under the x axis, snap index wraps a full turn
			'{1'b1, TWO, ONES, 3'd3, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0},
			// one lsb from the centre, exactly at tolerance
			'{1'b0, 32'd1, 32'd0, 3'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r])
			send_query(rows[r].mode, rows[r].qx, rows[r].qy, rows[r].n, rows[r].fixed,
				'{rows[r].ok, rows[r].px, rows[r].py, rows[r].gap});
		drain();

		// each phase sets a new circle, extremes among them
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin cx = 0; cy = 0; end
				1: begin cx = MAXP; cy = MINP; end
				2: begin cx = MINP; cy = MAXP; end
				default: begin cx = $urandom; cy = $urandom; end
			endcase
			if (phase >= 3 && $urandom_range(0, 1))
				begin cx = {{8{cx[31]}}, cx[23:0]}; cy = {{8{cy[31]}}, cy[23:0]}; end
			write_reg(REG_CENTER_X, cx);
			write_reg(REG_CENTER_Y, cy);
			case (phase)
				0: write_reg(REG_RADIUS, 32'd0);
				1: write_reg(REG_RADIUS, 32'h7fffffff);
				2: write_reg(REG_RADIUS, 32'd65535);
				3: write_reg(REG_RADIUS, 32'hffffffff);
				default: write_reg(REG_RADIUS, $urandom_range(0, 3) == 0
					? $urandom : $urandom_range(1, 32'h00400000));
			endcase
			case (phase)
				0: write_reg(REG_TOLERANCE, 32'd0);
				1: write_reg(REG_TOLERANCE, 32'h0000ffff);
				2: write_reg(REG_TOLERANCE, 32'd65535);
				default: write_reg(REG_TOLERANCE, $urandom_range(0, 1)
					? $urandom : $urandom_range(0, 64));
			endcase
			cfg_valid <= 1'b0;
			// no idling in the final phase
			idle_bursts = (phase < 8);
			repeat (62) begin
				pick = $urandom_range(0, 9);
				if (pick < 3) begin
					ox = $urandom;
					oy = $urandom;
				end else if (pick < 8) begin
					// around the circle
					ox = cx + {{10{1'b0}}, 22'($urandom)} - 32'h00200000;
					oy = cy + {{10{1'b0}}, 22'($urandom)} - 32'h00200000;
				end else begin
					// near or at the centre
					ox = cx + $urandom_range(0, 3) - 1;
					oy = cy + $urandom_range(0, 3) - 1;
				end
				send_query($urandom_range(0, 1), ox, oy, $urandom_range(0, 7), 1'b0, '0);
			end
			drain();
		end

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
design/csp_pkg.sv
design/csp_vec_cell.sv
design/csp_rot_cell.sv
design/csp_div_cell.sv
design/csp_vectoring.sv
design/circle_snap_point_finder.sv
sim/circle_snap_point_finder_tb.sv
